/* design/cadm_pkg.sv */
// Shared constants, status and command codes for the admission controller.
package cadm_pkg;

   localparam int ACTIVE_SLOTS = 16;
   localparam int WAIT_DEPTH   = 16;
   localparam int ID_BITS      = 16;

   localparam int ID_PORT_BITS = 16;
   localparam int KEY_BITS     = (ID_BITS < ID_PORT_BITS) ? ID_BITS : ID_PORT_BITS;

   localparam int ACT_IDX_BITS  = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
   localparam int WAIT_IDX_BITS = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int IDX_BITS      = (ACT_IDX_BITS > WAIT_IDX_BITS) ? ACT_IDX_BITS : WAIT_IDX_BITS;
   localparam int ALVL_BITS     = $clog2(ACTIVE_SLOTS + 1);
   localparam int WLVL_BITS     = $clog2(WAIT_DEPTH + 1);

   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd10;

   localparam logic [1:0] CMD_SUBMIT   = 2'd0;
   localparam logic [1:0] CMD_COMPLETE = 2'd1;
   localparam logic [1:0] CMD_WITHDRAW = 2'd2;

   localparam logic [3:0] ST_ADMITTED    = 4'd0;
   localparam logic [3:0] ST_QUEUED      = 4'd1;
   localparam logic [3:0] ST_WAITING     = 4'd2;
   localparam logic [3:0] ST_DUP_ACTIVE  = 4'd3;
   localparam logic [3:0] ST_WAIT_FULL   = 4'd4;
   localparam logic [3:0] ST_COMPLETED   = 4'd5;
   localparam logic [3:0] ST_NOT_ACTIVE  = 4'd6;
   localparam logic [3:0] ST_WITHDRAWN   = 4'd7;
   localparam logic [3:0] ST_NOT_WAITING = 4'd8;

endpackage

/* design/capacity_admission_with_wait_stack.sv */
// Admission controller with capacity limit, active table and LIFO wait stack.
// Time from accept to result valid depends on the command and on how far the scans run,
// set by one comparator checking one entry a cycle.
// One item is in work at a time; the next item is taken once the sequencer is idle,
// even while the previous result still waits.
// Synchronous active-high reset clears levels, valid bits, counters and capacity (10).
module capacity_admission_with_wait_stack (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_item_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic        rsp_promoted_valid,
   output logic [15:0] rsp_promoted_id,
   output logic        rsp_promoted_duplicate,
   output logic [31:0] rsp_received_count,
   output logic [31:0] rsp_refused_count,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data
);

   localparam int NACT = cadm_pkg::ACTIVE_SLOTS;
   localparam int NWT  = cadm_pkg::WAIT_DEPTH;
   localparam int KB   = cadm_pkg::KEY_BITS;
   localparam int AIB  = cadm_pkg::ACT_IDX_BITS;
   localparam int WIB  = cadm_pkg::WAIT_IDX_BITS;
   localparam int IB   = cadm_pkg::IDX_BITS;
   localparam int ALB  = cadm_pkg::ALVL_BITS;
   localparam int WLB  = cadm_pkg::WLVL_BITS;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_SCAN_ACT  = 3'd1;
   localparam logic [2:0] S_SCAN_WAIT = 3'd2;
   localparam logic [2:0] S_PUSH      = 3'd3;
   localparam logic [2:0] S_POP       = 3'd4;
   localparam logic [2:0] S_SHIFT     = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   logic [KB-1:0] active_ids [NACT];
   logic [KB-1:0] wait_stack [NWT];

   logic [2:0]     state_ff, state_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [KB-1:0]  key_ff, key_in;
   logic [IB-1:0]  idx_ff, idx_in;
   logic           promote_ff, promote_in;
   logic           free_found_ff, free_found_in;
   logic [AIB-1:0] free_idx_ff, free_idx_in;
   logic [3:0]     status_ff, status_in;
   logic           pv_ff, pv_in;
   logic [KB-1:0]  pid_ff, pid_in;
   logic           pdup_ff, pdup_in;

   logic [NACT-1:0] active_valid_ff, active_valid_in;
   logic [ALB-1:0]  active_level_ff, active_level_in;
   logic [WLB-1:0]  wait_level_ff, wait_level_in;
   logic [31:0]     received_ff, received_in;
   logic [31:0]     refused_ff, refused_in;
   logic [cadm_pkg::CAP_BITS-1:0] capacity_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_status_ff, rsp_status_in;
   logic        rsp_pv_ff, rsp_pv_in;
   logic [15:0] rsp_pid_ff, rsp_pid_in;
   logic        rsp_pdup_ff, rsp_pdup_in;
   logic [31:0] rsp_recv_ff, rsp_recv_in;
   logic [31:0] rsp_refu_ff, rsp_refu_in;

   logic           act_wr_en;
   logic [AIB-1:0] act_wr_idx;
   logic           ws_wr_en;
   logic [WIB-1:0] ws_wr_addr;
   logic [KB-1:0]  ws_wr_data;
   logic [WIB-1:0] ws_rd_addr;
   logic [KB-1:0]  ws_rd_data;
   logic [AIB-1:0] aidx;
   logic [WIB-1:0] widx;
   logic [KB-1:0]  cmp_b;
   logic           match;
   logic           act_hit;
   logic           act_last;
   logic           wait_last;
   logic           admit_ok;
   logic           complete_mode;

   assign aidx = idx_ff[AIB-1:0];
   assign widx = idx_ff[WIB-1:0];

   always_comb begin
      unique case (state_ff)
         S_SHIFT: ws_rd_addr = WIB'(32'(idx_ff) + 32'd1);
         S_POP:   ws_rd_addr = WIB'(wait_level_ff - WLB'(1));
         default: ws_rd_addr = widx;
      endcase
   end

   assign ws_rd_data = wait_stack[ws_rd_addr];
   assign cmp_b      = (state_ff == S_SCAN_ACT) ? active_ids[aidx] : ws_rd_data;
   assign match      = (key_ff == cmp_b);
   assign act_hit    = active_valid_ff[aidx] && match;
   assign act_last   = (aidx == AIB'(NACT - 1));
   assign wait_last  = ((32'(idx_ff) + 32'd1) == 32'(wait_level_ff));
   assign admit_ok   = (32'(active_level_ff) < 32'(capacity_ff)) &&
                       (32'(active_level_ff) < NACT);
   assign complete_mode = (cmd_ff == cadm_pkg::CMD_COMPLETE) && !promote_ff;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      idx_in          = idx_ff;
      promote_in      = promote_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      status_in       = status_ff;
      pv_in           = pv_ff;
      pid_in          = pid_ff;
      pdup_in         = pdup_ff;
      active_valid_in = active_valid_ff;
      active_level_in = active_level_ff;
      wait_level_in   = wait_level_ff;
      received_in     = received_ff;
      refused_in      = refused_ff;
      act_wr_en       = 1'b0;
      act_wr_idx      = aidx;
      ws_wr_en        = 1'b0;
      ws_wr_addr      = widx;
      ws_wr_data      = key_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pv_in     = rsp_pv_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_pdup_in   = rsp_pdup_ff;
      rsp_recv_in   = rsp_recv_ff;
      rsp_refu_in   = rsp_refu_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               key_in        = KB'(req_item_id);
               idx_in        = '0;
               promote_in    = 1'b0;
               free_found_in = 1'b0;
               status_in     = cadm_pkg::ST_ADMITTED;
               pv_in         = 1'b0;
               pid_in        = '0;
               pdup_in       = 1'b0;
               case (req_command)
                  cadm_pkg::CMD_SUBMIT: begin
                     if (admit_ok) begin
                        state_in = S_SCAN_ACT;
                     end else if (wait_level_ff == '0) begin
                        state_in = S_PUSH;
                     end else begin
                        state_in = S_SCAN_WAIT;
                     end
                  end
                  cadm_pkg::CMD_COMPLETE: begin
                     state_in = S_SCAN_ACT;
                  end
                  cadm_pkg::CMD_WITHDRAW: begin
                     if (wait_level_ff == '0) begin
                        status_in = cadm_pkg::ST_NOT_WAITING;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN_WAIT;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN_ACT: begin
            if (!active_valid_ff[aidx] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = aidx;
            end
            if (act_hit || act_last) begin
               if (complete_mode) begin
                  if (act_hit) begin
                     active_valid_in[aidx] = 1'b0;
                     active_level_in       = active_level_ff - ALB'(1);
                     status_in             = cadm_pkg::ST_COMPLETED;
                     state_in              = (wait_level_ff != '0) ? S_POP : S_DONE;
                  end else begin
                     status_in = cadm_pkg::ST_NOT_ACTIVE;
                     state_in  = S_DONE;
                  end
               end else begin
                  received_in = received_ff + 32'd1;
                  if (act_hit) begin
                     if (promote_ff) begin
                        pdup_in = 1'b1;
                     end else begin
                        status_in = cadm_pkg::ST_DUP_ACTIVE;
                     end
                  end else begin
                     act_wr_en  = 1'b1;
                     act_wr_idx = free_found_ff ? free_idx_ff : aidx;
                     active_valid_in[act_wr_idx] = 1'b1;
                     active_level_in = active_level_ff + ALB'(1);
                     if (!promote_ff) begin
                        status_in = cadm_pkg::ST_ADMITTED;
                     end
                  end
                  state_in = S_DONE;
               end
            end else begin
               idx_in = idx_ff + IB'(1);
            end
         end
         S_SCAN_WAIT: begin
            if (match) begin
               if (cmd_ff == cadm_pkg::CMD_SUBMIT) begin
                  status_in = cadm_pkg::ST_WAITING;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (wait_last) begin
               if (cmd_ff == cadm_pkg::CMD_SUBMIT) begin
                  state_in = S_PUSH;
               end else begin
                  status_in = cadm_pkg::ST_NOT_WAITING;
                  state_in  = S_DONE;
               end
            end else begin
               idx_in = idx_ff + IB'(1);
            end
         end
         S_PUSH: begin
            if (32'(wait_level_ff) >= NWT) begin
               status_in = cadm_pkg::ST_WAIT_FULL;
            end else begin
               ws_wr_en      = 1'b1;
               ws_wr_addr    = wait_level_ff[WIB-1:0];
               wait_level_in = wait_level_ff + WLB'(1);
               refused_in    = refused_ff + 32'd1;
               status_in     = cadm_pkg::ST_QUEUED;
            end
            state_in = S_DONE;
         end
         S_POP: begin
            key_in        = ws_rd_data;
            pid_in        = ws_rd_data;
            pv_in         = 1'b1;
            wait_level_in = wait_level_ff - WLB'(1);
            promote_in    = 1'b1;
            idx_in        = '0;
            free_found_in = 1'b0;
            state_in      = S_SCAN_ACT;
         end
         S_SHIFT: begin
            if ((32'(idx_ff) + 32'd1) < 32'(wait_level_ff)) begin
               ws_wr_en   = 1'b1;
               ws_wr_data = ws_rd_data;
               idx_in     = idx_ff + IB'(1);
            end else begin
               wait_level_in = wait_level_ff - WLB'(1);
               status_in     = cadm_pkg::ST_WITHDRAWN;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pv_in     = pv_ff;
               rsp_pid_in    = 16'(pid_ff);
               rsp_pdup_in   = pdup_ff;
               rsp_recv_in   = received_ff;
               rsp_refu_in   = refused_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         active_valid_ff <= '0;
         active_level_ff <= '0;
         wait_level_ff   <= '0;
         received_ff     <= '0;
         refused_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_valid_ff <= active_valid_in;
         active_level_ff <= active_level_in;
         wait_level_ff   <= wait_level_in;
         received_ff     <= received_in;
         refused_ff      <= refused_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= cadm_pkg::CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      promote_ff    <= promote_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      status_ff     <= status_in;
      pv_ff         <= pv_in;
      pid_ff        <= pid_in;
      pdup_ff       <= pdup_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pv_ff     <= rsp_pv_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_pdup_ff   <= rsp_pdup_in;
      rsp_recv_ff   <= rsp_recv_in;
      rsp_refu_ff   <= rsp_refu_in;
   end

   always_ff @(posedge clock) begin
      if (act_wr_en) begin
         active_ids[act_wr_idx] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ws_wr_en) begin
         wait_stack[ws_wr_addr] <= ws_wr_data;
      end
   end

   assign req_stall              = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_promoted_valid     = rsp_pv_ff;
   assign rsp_promoted_id        = rsp_pid_ff;
   assign rsp_promoted_duplicate = rsp_pdup_ff;
   assign rsp_received_count     = rsp_recv_ff;
   assign rsp_refused_count      = rsp_refu_ff;

endmodule

/* design/cadm_checker.sv */
// Port-level checker for the admission controller and its bind statement.
module cadm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_status,
   input logic        rsp_promoted_valid,
   input logic [15:0] rsp_promoted_id,
   input logic        rsp_promoted_duplicate
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_promoted_id))
      else $error("A stalled result item changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("The block took a second item while the first was in work.");

   a_promote_on_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_promoted_valid |-> rsp_status == cadm_pkg::ST_COMPLETED)
      else $error("A promotion came with a status other than completed.");

   a_no_promote_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_promoted_valid |-> rsp_promoted_id == 16'd0 &&
                                           !rsp_promoted_duplicate)
      else $error("Promotion fields are set without a promotion.");

endmodule

bind capacity_admission_with_wait_stack cadm_checker u_cadm_checker (.*);
